// ===== rtl/bfsk_pkg.sv =====
// Shared constants, types and the sine and cosine table builder for the FSK modulator.
package bfsk_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int SAMPLE_BITS     = 16;
	localparam int OUT_W           = 16;
	localparam int PHASE_W         = 32;
	localparam int MAX_SAMPLES     = 64;
	localparam int CNT_W           = $clog2(MAX_SAMPLES);

	localparam int MAG_W     = SAMPLE_BITS - 1;
	localparam int ROM_AW    = SINE_TABLE_BITS - 2;
	localparam int ROM_DEPTH = (1 << (SINE_TABLE_BITS - 3)) + 1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_STEP   = 2'd2;

	localparam logic [PHASE_W-1:0] SYMBOL_STEP_RESET = 32'h1000_0000;

	localparam logic [63:0] Q30_ONE    = 64'h0000_0000_4000_0000;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef logic [2*MAG_W-1:0] rom_word_t;
	typedef rom_word_t rom_t [ROM_DEPTH];

	// Scaled magnitude, rounded and clamped to the full-scale amplitude.
	function automatic logic [MAG_W-1:0] scale_mag(logic [63:0] m);
		logic [63:0] amp;
		logic [63:0] r;
		amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		r = (m * amp + (64'd1 << 29)) >> 30;
		if (r > amp) begin
			r = amp;
		end
		return r[MAG_W-1:0];
	endfunction

	// One table entry: cosine magnitude in the upper half, sine in the lower half.
	function automatic rom_word_t sincos_entry(int v);
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s0;
		logic [63:0] c0;
		f  = 64'(v) << (PHASE_W - SINE_TABLE_BITS);
		x  = (f * TWO_PI_Q30) >> 32;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s0 = (x * t) >> 30;
		t  = Q30_ONE - x2 / 56;
		t  = Q30_ONE - ((x2 * t) >> 30) / 30;
		t  = Q30_ONE - ((x2 * t) >> 30) / 12;
		c0 = Q30_ONE - ((x2 * t) >> 30) / 2;
		return {scale_mag(c0), scale_mag(s0)};
	endfunction

	function automatic rom_t build_rom();
		rom_t tab;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			tab[i] = sincos_entry(i);
		end
		return tab;
	endfunction

	localparam rom_t SINCOS_ROM = build_rom();

endpackage

// ===== rtl/bfsk_sincos_rom.sv =====
// First-octant sine and cosine table with a registered read port.
module bfsk_sincos_rom (
	input  logic                       clk,
	input  logic                       en,
	input  logic [bfsk_pkg::ROM_AW-1:0] addr,
	output bfsk_pkg::rom_word_t        data
);

	localparam bfsk_pkg::rom_t ROM = bfsk_pkg::SINCOS_ROM;

	always_ff @(posedge clk) begin
		if (en) begin
			data <= ROM[addr];
		end
	end

endmodule

// ===== rtl/binary_fsk_modulator.sv =====
// Binary FSK modulator: one frame bit in, a run of complex baseband samples out.
// The slave stream takes one frame bit per request: tdata bit 0 is the bit (1 = mark,
// 0 = space) and tlast marks the final bit of the frame. For every sample the mark
// or space step is added to a 32-bit carrier phase and the cosine and sine of the
// new phase leave on the master stream, with tdata = {quadrature, in_phase}. A
// 32-bit symbol phase grows by symbol_step per sample; the sample on which it
// wraps, or the 64th sample, ends the bit and carries tlast. tuser is set on that
// sample when the bit closed the frame. Both phases carry over between bits and
// frames.
// A bit of n samples is generated at one sample per cycle unless the receiver stalls;
// the slave side is busy until the last sample is generated and takes the next bit in
// the cycle after. Each sample passes through the table address register, the
// registered table read and the output register. Registers are written through cfg_we,
// cfg_index and cfg_data only while idle: a rule for the user, with no check in the block.
// Reset clears both phases, loads symbol_step with 2^28 and zeroes both steps.
// When the receiver stalls, the whole sample pipeline holds and no sample is lost.
module binary_fsk_modulator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [0] data_bit, [7:1] zero
	input  logic                             s_tlast,   // last_in_frame
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // [15:0] in_phase, [31:16] quadrature
	output logic                             m_tlast,   // last_of_symbol
	output logic                             m_tuser,   // end_of_frame
	input  logic                             cfg_we,
	input  logic [bfsk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfsk_pkg::PHASE_W-1:0]     cfg_data
);

	typedef struct packed {
		logic       valid;
		logic [1:0] quad;
		logic       swap;
		logic       last;
		logic       eof;
	} smp_ctl_t;

	logic [bfsk_pkg::PHASE_W-1:0] symbol_step_q;
	logic [bfsk_pkg::PHASE_W-1:0] space_step_q;
	logic [bfsk_pkg::PHASE_W-1:0] mark_step_q;
	logic [bfsk_pkg::PHASE_W-1:0] carrier_q;
	logic [bfsk_pkg::PHASE_W-1:0] symbol_q;
	logic                         busy_q;
	logic                         bit_q;
	logic                         lif_q;
	logic [bfsk_pkg::CNT_W-1:0]   cnt_q;

	smp_ctl_t                      ctl_s1;
	smp_ctl_t                      ctl_s2;
	logic [bfsk_pkg::ROM_AW-1:0]   addr_s1;
	bfsk_pkg::rom_word_t           rom_data;

	logic                          advance;
	logic                          gen;
	logic [bfsk_pkg::PHASE_W-1:0]  carrier_next;
	logic [bfsk_pkg::PHASE_W:0]    symbol_sum;
	logic                          done;
	logic [bfsk_pkg::ROM_AW-1:0]   offset;
	logic [bfsk_pkg::ROM_AW:0]     folded;
	logic [bfsk_pkg::MAG_W-1:0]    sin_mag;
	logic [bfsk_pkg::MAG_W-1:0]    cos_mag;
	logic [31:0]                   c_ext;
	logic [31:0]                   s_ext;
	logic [31:0]                   i_val;
	logic [31:0]                   q_val;

	assign advance  = !m_tvalid || m_tready;
	assign gen      = busy_q && advance;
	assign s_tready = !busy_q;

	assign carrier_next = carrier_q + (bit_q ? mark_step_q : space_step_q);
	assign symbol_sum   = {1'b0, symbol_q} + {1'b0, symbol_step_q};
	assign done = symbol_sum[bfsk_pkg::PHASE_W]
		|| (cnt_q == bfsk_pkg::CNT_W'(bfsk_pkg::MAX_SAMPLES - 1));

	// The quadrant offset is folded about the octant so the table covers one eighth turn.
	assign offset = carrier_next[bfsk_pkg::PHASE_W-3 -: bfsk_pkg::ROM_AW];
	assign folded = (bfsk_pkg::ROM_AW + 1)'(1 << bfsk_pkg::ROM_AW) - {1'b0, offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_step_q <= bfsk_pkg::SYMBOL_STEP_RESET;
			space_step_q  <= '0;
			mark_step_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfsk_pkg::REG_SYMBOL_STEP: symbol_step_q <= cfg_data;
				bfsk_pkg::REG_SPACE_STEP:  space_step_q  <= cfg_data;
				bfsk_pkg::REG_MARK_STEP:   mark_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			symbol_q  <= '0;
			busy_q    <= 1'b0;
			cnt_q     <= '0;
		end else if (s_tvalid && s_tready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (gen) begin
			carrier_q <= carrier_next;
			symbol_q  <= symbol_sum[bfsk_pkg::PHASE_W-1:0];
			cnt_q     <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			bit_q <= s_tdata[0];
			lif_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			addr_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid <= gen;
			ctl_s1.quad  <= carrier_next[bfsk_pkg::PHASE_W-1 -: 2];
			ctl_s1.swap  <= offset[bfsk_pkg::ROM_AW-1];
			ctl_s1.last  <= done;
			ctl_s1.eof   <= done && lif_q;
			addr_s1      <= offset[bfsk_pkg::ROM_AW-1] ? folded[bfsk_pkg::ROM_AW-1:0] : offset;
			ctl_s2       <= ctl_s1;
		end
	end

	bfsk_sincos_rom u_rom (
		.clk  (clk),
		.en   (advance),
		.addr (addr_s1),
		.data (rom_data)
	);

	assign sin_mag = rom_data[bfsk_pkg::MAG_W-1:0];
	assign cos_mag = rom_data[2*bfsk_pkg::MAG_W-1:bfsk_pkg::MAG_W];

	always_comb begin
		c_ext = 32'(ctl_s2.swap ? sin_mag : cos_mag);
		s_ext = 32'(ctl_s2.swap ? cos_mag : sin_mag);
		case (ctl_s2.quad)
			2'd0: begin
				i_val = c_ext;
				q_val = s_ext;
			end
			2'd1: begin
				i_val = -s_ext;
				q_val = c_ext;
			end
			2'd2: begin
				i_val = -c_ext;
				q_val = -s_ext;
			end
			default: begin
				i_val = s_ext;
				q_val = -c_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {q_val[bfsk_pkg::OUT_W-1:0], i_val[bfsk_pkg::OUT_W-1:0]};
			m_tlast <= ctl_s2.last;
			m_tuser <= ctl_s2.eof;
		end
	end

endmodule

// ===== bench/binary_fsk_modulator_tb.sv =====
// Self-checking testbench for the binary FSK modulator, with a local NCO and sine predictor.
`timescale 1ns / 1ps

module binary_fsk_modulator_tb;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 11;
	localparam int STALL_LIMIT     = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 10;
	localparam int REPORT_MAX      = 10;

	localparam logic [bfsk_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam logic [63:0] ONE_Q30    = 64'h0000_0000_4000_0000;
	localparam logic [63:0] TAU_Q30    = 64'd6746518852;
	localparam logic [63:0] FULL_SCALE = (64'd1 << (bfsk_pkg::SAMPLE_BITS - 1)) - 64'd1;
	localparam int          TRUNC_BITS = bfsk_pkg::PHASE_W - bfsk_pkg::SINE_TABLE_BITS;

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;

	typedef struct packed {
		logic [bfsk_pkg::OUT_W-1:0] in_phase;
		logic [bfsk_pkg::OUT_W-1:0] quadrature;
		logic                       last_of_symbol;
		logic                       end_of_frame;
	} iq_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;    // [0] data_bit, [7:1] zero
	logic                           s_tlast;    // last_in_frame
	logic                           m_tvalid;
	logic                           m_tready;
	logic [31:0]                    m_tdata;    // [15:0] in_phase, [31:16] quadrature
	logic                           m_tlast;    // last_of_symbol
	logic                           m_tuser;    // end_of_frame
	logic                           cfg_we;
	logic [bfsk_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bfsk_pkg::PHASE_W-1:0]   cfg_data;

	// Predictor state and register copies.
	logic [31:0] nco_carrier;
	logic [31:0] nco_symbol;
	logic [31:0] step_symbol;
	logic [31:0] step_space;
	logic [31:0] step_mark;

	iq_result_t expected_samples[$];

	bit tx_gaps_on  = 1'b1;
	bit rx_gaps_on  = 1'b1;
	bit rx_hold_req = 1'b0;

	int bits_sent    = 0;
	int samples_seen = 0;
	int frame_ends   = 0;
	int reg_writes   = 0;
	int mismatches   = 0;
	int idle_cycles  = 0;

	binary_fsk_modulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [63:0] taylor_sine(logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t  = ONE_Q30 - x2 / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		return (x * t) >> 30;
	endfunction

	function automatic logic [63:0] taylor_cosine(logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t  = ONE_Q30 - x2 / 64'd56;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
		return ONE_Q30 - ((x2 * t) >> 30) / 64'd2;
	endfunction

	function automatic logic [bfsk_pkg::OUT_W-1:0] to_amplitude(logic [63:0] mag_q30);
		logic [63:0] r;
		r = (mag_q30 * FULL_SCALE + (64'd1 << 29)) >> 30;
		if (r > FULL_SCALE) begin
			r = FULL_SCALE;
		end
		return r[bfsk_pkg::OUT_W-1:0];
	endfunction

	// Cosine and sine of the truncated phase; the second half of each quadrant is folded back.
	function automatic void carrier_iq(input logic [31:0] phase,
			output logic [bfsk_pkg::OUT_W-1:0] i_val, output logic [bfsk_pkg::OUT_W-1:0] q_val);
		logic [31:0]                p;
		logic [63:0]                f;
		logic [63:0]                x;
		logic [63:0]                s_q30;
		logic [63:0]                c_q30;
		logic [bfsk_pkg::OUT_W-1:0] s_mag;
		logic [bfsk_pkg::OUT_W-1:0] c_mag;
		p = (phase >> TRUNC_BITS) << TRUNC_BITS;
		f = 64'(p[29:0]);
		if (f < (64'd1 << 29)) begin
			x     = (f * TAU_Q30) >> 32;
			s_q30 = taylor_sine(x);
			c_q30 = taylor_cosine(x);
		end else begin
			x     = (((64'd1 << 30) - f) * TAU_Q30) >> 32;
			s_q30 = taylor_cosine(x);
			c_q30 = taylor_sine(x);
		end
		s_mag = to_amplitude(s_q30);
		c_mag = to_amplitude(c_q30);
		case (quadrant_t'(p[31:30]))
			QUAD_0: begin
				i_val = c_mag;
				q_val = s_mag;
			end
			QUAD_1: begin
				i_val = -s_mag;
				q_val = c_mag;
			end
			QUAD_2: begin
				i_val = -c_mag;
				q_val = -s_mag;
			end
			default: begin
				i_val = s_mag;
				q_val = -c_mag;
			end
		endcase
	endfunction

	task automatic predict_bit(input logic data_bit, input logic frame_last);
		logic [31:0]                step;
		logic [31:0]                prev;
		logic [bfsk_pkg::OUT_W-1:0] i_val;
		logic [bfsk_pkg::OUT_W-1:0] q_val;
		iq_result_t                 s;
		bit                         done;
		step = data_bit ? step_mark : step_space;
		for (int n = 0; n < bfsk_pkg::MAX_SAMPLES; n++) begin
			nco_carrier = nco_carrier + step;
			carrier_iq(nco_carrier, i_val, q_val);
			prev       = nco_symbol;
			nco_symbol = nco_symbol + step_symbol;
			// The 64th sample closes the bit even when the symbol phase has not wrapped.
			done = (nco_symbol < prev) || (n == bfsk_pkg::MAX_SAMPLES - 1);
			s.in_phase       = i_val;
			s.quadrature     = q_val;
			s.last_of_symbol = done;
			s.end_of_frame   = done & frame_last;
			expected_samples.push_back(s);
			if (done) begin
				break;
			end
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(0, 2);
	endfunction

	task automatic set_idling(input bit tx_on, input bit rx_on);
		@(posedge clk);
		tx_gaps_on = tx_on;
		rx_gaps_on = rx_on;
	endtask

	task automatic send_bit(input logic data_bit, input logic frame_last);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			if (s_tvalid) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				gap--;
			end
			repeat (gap) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, data_bit};
		s_tlast  <= frame_last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_bit(data_bit, frame_last);
		bits_sent++;
	endtask

	// Drop the request line and wait until every expected sample has been checked.
	task automatic wait_for_drain();
		if (s_tvalid) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		while (expected_samples.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [bfsk_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		wait_for_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bfsk_pkg::REG_SYMBOL_STEP: step_symbol = value;
			bfsk_pkg::REG_SPACE_STEP:  step_space  = value;
			bfsk_pkg::REG_MARK_STEP:   step_mark   = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic apply_settings(input logic [31:0] sym, input logic [31:0] space,
			input logic [31:0] mark);
		write_register(bfsk_pkg::REG_SYMBOL_STEP, sym);
		write_register(bfsk_pkg::REG_SPACE_STEP, space);
		write_register(bfsk_pkg::REG_MARK_STEP, mark);
	endtask

	function automatic logic [31:0] rand_symbol_step();
		case ($urandom_range(0, 7))
			0: return 32'h0400_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(32'h0400_0000, 32'hFFFF_FFFF);
			default: return $urandom_range(32'h0800_0000, 32'h4000_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_carrier_step();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {10'($urandom_range(0, 1023)), 22'd0};
			default: return $urandom();
		endcase
	endfunction

	// With both steps zero after reset the carrier sits at phase zero: full-scale cosine.
	task automatic test_reset_state();
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
	endtask

	task automatic test_register_map();
		write_register(REG_NONE, 32'hDEAD_BEEF);
		apply_settings(32'h4000_0000, 32'h0040_0000, 32'hFFC0_0000);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b1);
		write_register(REG_NONE, 32'h0000_0001);
		send_bit(1'b0, 1'b1);
	endtask

	task automatic test_symbol_extremes();
		apply_settings(32'hFFFF_FFFF, 32'h0123_4567, 32'h89AB_CDEF);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		write_register(bfsk_pkg::REG_SYMBOL_STEP, 32'h0400_0000);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		// A slow symbol rate usually does not wrap in time, so the bit is cut at 64 samples.
		write_register(bfsk_pkg::REG_SYMBOL_STEP, 32'h0010_0000);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
	endtask

	task automatic test_step_extremes();
		apply_settings(32'h2000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
		apply_settings(32'h2000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		apply_settings(32'h1000_0000, 32'h1000_0000, 32'h8000_0000);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(input int phases, input int per_phase);
		int left;
		int frame_len;
		for (int p = 0; p < phases; p++) begin
			apply_settings(rand_symbol_step(), rand_carrier_step(), rand_carrier_step());
			case (p % 4)
				0: set_idling(1'b1, 1'b1);
				1: set_idling(1'b1, 1'b0);
				2: set_idling(1'b0, 1'b1);
				default: set_idling(1'b0, 1'b0);
			endcase
			left = per_phase;
			while (left > 0) begin
				frame_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
				for (int k = 0; k < frame_len && left > 0; k++) begin
					send_bit(1'($urandom_range(0, 1)), (k == frame_len - 1) || (left == 1));
					left--;
				end
			end
		end
		set_idling(1'b1, 1'b1);
	endtask

	// The receiver holds off while requests keep coming, so the block fills and stalls.
	task automatic test_backpressure();
		apply_settings(32'h1000_0000, rand_carrier_step(), rand_carrier_step());
		set_idling(1'b0, 1'b0);
		rx_hold_req = 1'b1;
		for (int k = 0; k < 8; k++) begin
			send_bit(1'($urandom_range(0, 1)), k == 7);
		end
		wait_for_drain();
		for (int k = 0; k < 4; k++) begin
			send_bit(1'($urandom_range(0, 1)), k == 3);
		end
		set_idling(1'b1, 1'b1);
	endtask

	initial begin : stimulus
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = bfsk_pkg::REG_SYMBOL_STEP;
		cfg_data    = '0;
		nco_carrier = '0;
		nco_symbol  = '0;
		step_symbol = bfsk_pkg::SYMBOL_STEP_RESET;
		step_space  = '0;
		step_mark   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_register_map();
		test_symbol_extremes();
		test_step_extremes();
		test_random_traffic(5, 44);
		test_backpressure();
		wait_for_drain();

		$display("Run covered %0d bits, %0d samples and %0d frame ends over %0d register writes,",
			bits_sent, samples_seen, frame_ends, reg_writes);
		$display("with random gaps, a long receiver hold-off and full drains on both streams.");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin : sample_check
		iq_result_t want;
		iq_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.in_phase       = m_tdata[15:0];
			got.quadrature     = m_tdata[31:16];
			got.last_of_symbol = m_tlast;
			got.end_of_frame   = m_tuser;
			samples_seen++;
			if (got.end_of_frame) begin
				frame_ends++;
			end
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: sample I=%0d Q=%0d last=%b eof=%b arrived with none expected",
						$realtime, $signed(got.in_phase), $signed(got.quadrature),
						got.last_of_symbol, got.end_of_frame);
				end
			end else begin
				want = expected_samples.pop_front();
				if (got.in_phase !== want.in_phase || got.quadrature !== want.quadrature ||
						got.last_of_symbol !== want.last_of_symbol ||
						got.end_of_frame !== want.end_of_frame) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("%0t: expected I=%0d Q=%0d last=%b eof=%b, got I=%0d Q=%0d last=%b eof=%b",
							$realtime, $signed(want.in_phase), $signed(want.quadrature),
							want.last_of_symbol, want.end_of_frame, $signed(got.in_phase),
							$signed(got.quadrature), got.last_of_symbol, got.end_of_frame);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no request moved for %0d cycles, %0d samples still expected.",
				idle_cycles, expected_samples.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
